// File: sv/sma_pkg.sv
// Package for the stack machine ALU: opcode and status codes, microcode
// word layout, microcode ROM and opcode dispatch table.
// No dependencies.
package sma_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int LINE_W          = 16;
    localparam int COUNT_W         = 9;
    localparam int DIV_STEPS       = 32;

    localparam logic [2:0] FUNC_SKIP = 3'd0;
    localparam logic [2:0] FUNC_PUSH = 3'd1;
    localparam logic [2:0] FUNC_SWAP = 3'd2;
    localparam logic [2:0] FUNC_ADD  = 3'd3;
    localparam logic [2:0] FUNC_SUB  = 3'd4;
    localparam logic [2:0] FUNC_DIV  = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_DIVZERO  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_HALTED   = 3'd4;

    typedef logic [4:0] t_uaddr;

    localparam t_uaddr UA_IDLE     = 5'd0;
    localparam t_uaddr UA_HALTED   = 5'd1;
    localparam t_uaddr UA_NOP      = 5'd2;
    localparam t_uaddr UA_PUSH     = 5'd3;
    localparam t_uaddr UA_PUSH_DO  = 5'd4;
    localparam t_uaddr UA_OVF      = 5'd5;
    localparam t_uaddr UA_BIN      = 5'd6;
    localparam t_uaddr UA_BIN_SWAP = 5'd7;
    localparam t_uaddr UA_BIN_DIV  = 5'd8;
    localparam t_uaddr UA_ARITH    = 5'd9;
    localparam t_uaddr UA_SWAP_A   = 5'd10;
    localparam t_uaddr UA_SWAP_B   = 5'd11;
    localparam t_uaddr UA_DIV_CHK  = 5'd12;
    localparam t_uaddr UA_DIV_INIT = 5'd13;
    localparam t_uaddr UA_DIV_LOOP = 5'd14;
    localparam t_uaddr UA_DIV_WR   = 5'd15;
    localparam t_uaddr UA_FEW      = 5'd16;
    localparam t_uaddr UA_DZ       = 5'd17;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_READ_S,
        ACT_ARITH,
        ACT_SWAP_A,
        ACT_SWAP_B,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_DIV_WR
    } t_act;

    typedef enum logic [3:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_START,
        COND_FULL,
        COND_FEW,
        COND_SWAP,
        COND_DIV,
        COND_TZERO,
        COND_DIV_BUSY
    } t_cond;

    typedef enum logic [2:0] {
        RESP_NONE,
        RESP_OK,
        RESP_FEW,
        RESP_DZ,
        RESP_OVF,
        RESP_HALT
    } t_resp;

    typedef struct packed {
        t_act   act;
        t_cond  cond;
        t_resp  resp;
        t_uaddr target;
    } t_uword;

    function automatic t_uword ucode_rom(input t_uaddr addr);
        t_uword w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, resp: RESP_NONE, target: UA_IDLE};
        unique case (addr)
            UA_IDLE:     w = '{ACT_NONE,     COND_START,    RESP_NONE, UA_IDLE};
            UA_HALTED:   w = '{ACT_NONE,     COND_ALWAYS,   RESP_HALT, UA_IDLE};
            UA_NOP:      w = '{ACT_NONE,     COND_ALWAYS,   RESP_OK,   UA_IDLE};
            UA_PUSH:     w = '{ACT_NONE,     COND_FULL,     RESP_NONE, UA_OVF};
            UA_PUSH_DO:  w = '{ACT_PUSH,     COND_ALWAYS,   RESP_OK,   UA_IDLE};
            UA_OVF:      w = '{ACT_NONE,     COND_ALWAYS,   RESP_OVF,  UA_IDLE};
            UA_BIN:      w = '{ACT_READ_S,   COND_FEW,      RESP_NONE, UA_FEW};
            UA_BIN_SWAP: w = '{ACT_NONE,     COND_SWAP,     RESP_NONE, UA_SWAP_A};
            UA_BIN_DIV:  w = '{ACT_NONE,     COND_DIV,      RESP_NONE, UA_DIV_CHK};
            UA_ARITH:    w = '{ACT_ARITH,    COND_ALWAYS,   RESP_OK,   UA_IDLE};
            UA_SWAP_A:   w = '{ACT_SWAP_A,   COND_NEXT,     RESP_NONE, UA_IDLE};
            UA_SWAP_B:   w = '{ACT_SWAP_B,   COND_ALWAYS,   RESP_OK,   UA_IDLE};
            UA_DIV_CHK:  w = '{ACT_NONE,     COND_TZERO,    RESP_NONE, UA_DZ};
            UA_DIV_INIT: w = '{ACT_DIV_INIT, COND_NEXT,     RESP_NONE, UA_IDLE};
            UA_DIV_LOOP: w = '{ACT_DIV_STEP, COND_DIV_BUSY, RESP_NONE, UA_DIV_LOOP};
            UA_DIV_WR:   w = '{ACT_DIV_WR,   COND_ALWAYS,   RESP_OK,   UA_IDLE};
            UA_FEW:      w = '{ACT_NONE,     COND_ALWAYS,   RESP_FEW,  UA_IDLE};
            UA_DZ:       w = '{ACT_NONE,     COND_ALWAYS,   RESP_DZ,   UA_IDLE};
            default:     w = '{ACT_NONE,     COND_ALWAYS,   RESP_NONE, UA_IDLE};
        endcase
        return w;
    endfunction

    function automatic t_uaddr dispatch(input logic [2:0] f);
        t_uaddr a;
        unique case (f) inside
            FUNC_PUSH:                               a = UA_PUSH;
            FUNC_SWAP, FUNC_ADD, FUNC_SUB, FUNC_DIV: a = UA_BIN;
            default:                                 a = UA_NOP;
        endcase
        return a;
    endfunction

endpackage

// File: sv/stack_machine_alu.sv
// Stack machine ALU top level: microcoded sequencer, stack memory,
// adder and radix-2 restoring divider. Depends on sma_pkg.
//
// Usage:
//   Command channel: drive i_func, i_push_value and i_line_number with
//   start high; the transaction is taken at the rising edge where start is
//   high and busy is low. busy is high while the microprogram runs.
//   Result channel: o_strobe is high for exactly one cycle with o_status,
//   o_top_value, o_stack_count and o_error_line. The receiver cannot stall;
//   a result must be taken in the cycle it appears.
// Sequencing: busy falls as the result strobe rises, so a new transaction
//   is taken only once the last one has produced its result. div runs the
//   32-step restoring divider loop; the other operations are paced by the
//   single-port stack memory with its registered read.
// Reset (i_rst_n low, synchronous): stack empty, block running, no
//   result pending. The stack memory holds no reset value and needs no
//   clearing pass. After a too-few-entries or divide-by-zero error every
//   transaction answers status halted until the next reset.
module stack_machine_alu #(
    parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_func,
    input  logic signed [sma_pkg::DATA_W-1:0]   i_push_value,
    input  logic [sma_pkg::LINE_W-1:0]          i_line_number,
    output logic                                o_strobe,
    output logic [2:0]                          o_status,
    output logic signed [sma_pkg::DATA_W-1:0]   o_top_value,
    output logic [sma_pkg::COUNT_W-1:0]         o_stack_count,
    output logic [sma_pkg::LINE_W-1:0]          o_error_line
);
    import sma_pkg::*;

    localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    t_uaddr              r_pc, n_pc;
    logic [SP_W-1:0]     r_sp, n_sp;
    logic                r_halted, n_halted;
    logic [DATA_W-1:0]   r_top, n_top;
    logic [DATA_W-1:0]   r_rd;
    logic [2:0]          r_func;
    logic [DATA_W-1:0]   r_pval;
    logic [LINE_W-1:0]   r_line;

    logic [DATA_W-1:0]   r_dvs, r_quo, r_rem;
    logic [4:0]          r_cnt;
    logic                r_qneg;

    logic                r_strobe;
    logic [2:0]          r_status;
    logic [DATA_W-1:0]   r_out_top;
    logic [COUNT_W-1:0]  r_count;
    logic [LINE_W-1:0]   r_err_line;

    t_uword              uw;
    logic                accept;
    logic                flag;
    logic [SP_W-1:0]     sp_m1, sp_m2;
    logic                mem_we, mem_re;
    logic [AW-1:0]       waddr;
    logic [DATA_W-1:0]   wdata;
    logic [DATA_W-1:0]   arith_res, quo_signed;
    logic [DATA_W:0]     rem_sh, rem_diff;
    logic [2:0]          n_status;
    logic [LINE_W-1:0]   n_err_line;

    assign uw     = ucode_rom(r_pc);
    assign busy   = (r_pc != UA_IDLE);
    assign accept = start && !busy;
    assign sp_m1  = r_sp - SP_W'(1);
    assign sp_m2  = r_sp - SP_W'(2);

    assign arith_res  = (r_func == FUNC_ADD) ? (r_rd + r_top) : (r_rd - r_top);
    assign quo_signed = r_qneg ? (DATA_W'(0) - r_quo) : r_quo;
    assign rem_sh     = {r_rem, r_quo[DATA_W-1]};
    assign rem_diff   = rem_sh - {1'b0, r_dvs};

    always_comb begin
        unique case (uw.cond)
            COND_FULL:     flag = (r_sp == SP_W'(STACK_DEPTH));
            COND_FEW:      flag = (r_sp < SP_W'(2));
            COND_SWAP:     flag = (r_func == FUNC_SWAP);
            COND_DIV:      flag = (r_func == FUNC_DIV);
            COND_TZERO:    flag = (r_top == '0);
            COND_DIV_BUSY: flag = (r_cnt != 5'(DIV_STEPS - 1));
            default:       flag = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            COND_NEXT:   n_pc = r_pc + t_uaddr'(1);
            COND_ALWAYS: n_pc = uw.target;
            COND_START: begin
                if (!accept) begin
                    n_pc = r_pc;
                end else if (r_halted) begin
                    n_pc = UA_HALTED;
                end else begin
                    n_pc = dispatch(i_func);
                end
            end
            default:     n_pc = flag ? uw.target : (r_pc + t_uaddr'(1));
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        waddr  = sp_m2[AW-1:0];
        wdata  = r_top;
        n_sp   = r_sp;
        n_top  = r_top;
        unique case (uw.act)
            ACT_PUSH: begin
                mem_we = 1'b1;
                waddr  = r_sp[AW-1:0];
                wdata  = r_pval;
                n_top  = r_pval;
                n_sp   = r_sp + SP_W'(1);
            end
            ACT_READ_S: begin
                mem_re = 1'b1;
            end
            ACT_ARITH: begin
                mem_we = 1'b1;
                wdata  = arith_res;
                n_top  = arith_res;
                n_sp   = sp_m1;
            end
            ACT_SWAP_A: begin
                mem_we = 1'b1;
                waddr  = sp_m1[AW-1:0];
                wdata  = r_rd;
            end
            ACT_SWAP_B: begin
                mem_we = 1'b1;
                wdata  = r_top;
                n_top  = r_rd;
            end
            ACT_DIV_WR: begin
                mem_we = 1'b1;
                wdata  = quo_signed;
                n_top  = quo_signed;
                n_sp   = sp_m1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_halted   = r_halted;
        n_status   = ST_OK;
        n_err_line = '0;
        unique case (uw.resp)
            RESP_FEW: begin
                n_status   = ST_FEW;
                n_err_line = r_line;
                n_halted   = 1'b1;
            end
            RESP_DZ: begin
                n_status   = ST_DIVZERO;
                n_err_line = r_line;
                n_halted   = 1'b1;
            end
            RESP_OVF: begin
                n_status   = ST_OVERFLOW;
                n_err_line = r_line;
            end
            RESP_HALT: n_status = ST_HALTED;
            default:   n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd <= mem[sp_m2[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= UA_IDLE;
            r_sp     <= '0;
            r_halted <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_sp     <= n_sp;
            r_halted <= n_halted;
            r_strobe <= (uw.resp != RESP_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (accept) begin
            r_func <= i_func;
            r_pval <= i_push_value;
            r_line <= i_line_number;
        end
        if (uw.act == ACT_DIV_INIT) begin
            r_dvs  <= r_top[DATA_W-1] ? (DATA_W'(0) - r_top) : r_top;
            r_quo  <= r_rd[DATA_W-1] ? (DATA_W'(0) - r_rd) : r_rd;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_qneg <= r_top[DATA_W-1] ^ r_rd[DATA_W-1];
        end else if (uw.act == ACT_DIV_STEP) begin
            r_cnt <= r_cnt + 5'd1;
            if (!rem_diff[DATA_W]) begin
                r_rem <= rem_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
        if (uw.resp != RESP_NONE) begin
            r_status   <= n_status;
            r_out_top  <= (n_sp != '0) ? n_top : '0;
            r_count    <= COUNT_W'(n_sp);
            r_err_line <= n_err_line;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_top_value   = r_out_top;
    assign o_stack_count = r_count;
    assign o_error_line  = r_err_line;

`ifndef NO_ASSERTIONS
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_pc != UA_IDLE))
        else $error("result strobe without a running microprogram");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == ST_HALTED)) |-> r_halted)
        else $error("halted status while running");
`endif

endmodule

// File: tb/stack_machine_alu_checker.sv
// Result checker for stack_machine_alu: watches the command and result channels,
// predicts every result from its own stack model and compares field by field.
// Depends on sma_pkg for opcode and status codes.
module stack_machine_alu_checker #(
    parameter int DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_push_value,
    input  logic [15:0] i_line_number,
    input  logic        i_strobe,
    input  logic [2:0]  i_status,
    input  logic [31:0] i_top_value,
    input  logic [8:0]  i_stack_count,
    input  logic [15:0] i_error_line,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sma_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] top;
        logic [8:0]  count;
        logic [15:0] err_line;
    } t_alu_result;

    logic [31:0] stack_mem [DEPTH];
    int          sp;
    bit          halted;
    t_alu_result results_due [$];

    function automatic logic [31:0] div_toward_zero(logic [31:0] num, logic [31:0] den);
        logic [31:0] num_mag;
        logic [31:0] den_mag;
        logic [31:0] quo;
        num_mag = num[31] ? (32'd0 - num) : num;
        den_mag = den[31] ? (32'd0 - den) : den;
        quo     = num_mag / den_mag;
        return (num[31] ^ den[31]) ? (32'd0 - quo) : quo;
    endfunction

    function automatic t_alu_result run_opcode(logic [2:0] func, logic [31:0] pval,
                                               logic [15:0] line);
        t_alu_result res;
        logic [31:0] top_w;
        logic [31:0] sec_w;
        bit          failed;
        res.status = ST_OK;
        failed     = 1'b0;
        if (halted) begin
            res.status = ST_HALTED;
        end else begin
            case (func)
                FUNC_PUSH: begin
                    if (sp >= DEPTH) begin
                        res.status = ST_OVERFLOW;
                        failed     = 1'b1;
                    end else begin
                        stack_mem[sp] = pval;
                        sp++;
                    end
                end
                FUNC_SWAP, FUNC_ADD, FUNC_SUB, FUNC_DIV: begin
                    if (sp < 2) begin
                        res.status = ST_FEW;
                        failed     = 1'b1;
                        halted     = 1'b1;
                    end else begin
                        top_w = stack_mem[sp-1];
                        sec_w = stack_mem[sp-2];
                        if (func == FUNC_SWAP) begin
                            stack_mem[sp-1] = sec_w;
                            stack_mem[sp-2] = top_w;
                        end else if (func == FUNC_DIV && top_w == 32'd0) begin
                            res.status = ST_DIVZERO;
                            failed     = 1'b1;
                            halted     = 1'b1;
                        end else begin
                            case (func)
                                FUNC_ADD: stack_mem[sp-2] = sec_w + top_w;
                                FUNC_SUB: stack_mem[sp-2] = sec_w - top_w;
                                default:  stack_mem[sp-2] = div_toward_zero(sec_w, top_w);
                            endcase
                            sp--;
                        end
                    end
                end
                default: ;
            endcase
        end
        res.top      = (sp > 0) ? stack_mem[sp-1] : 32'd0;
        res.count    = 9'(sp);
        res.err_line = failed ? line : 16'd0;
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_alu_result want;
        if (!i_rst_n) begin
            sp     = 0;
            halted = 1'b0;
            results_due.delete();
        end else begin
            if (i_strobe) begin
                if (results_due.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("status", 32'(want.status), 32'(i_status));
                    compare_field("top_value", want.top, i_top_value);
                    compare_field("stack_count", 32'(want.count), 32'(i_stack_count));
                    compare_field("error_line", 32'(want.err_line), 32'(i_error_line));
                end
            end
            if (i_start && !i_busy)
                results_due.push_back(run_opcode(i_func, i_push_value, i_line_number));
        end
        o_pending = results_due.size();
    end

endmodule

// File: tb/stack_machine_alu_tb.sv
// Top of the stack_machine_alu testbench: clock, reset and command stimulus.
// Depends on sma_pkg, stack_machine_alu and stack_machine_alu_checker.
module stack_machine_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sma_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          WALK_ITEMS   = 20;
    localparam int          DRAIN_CYCLES = 60;
    localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
    localparam logic [2:0]  FUNC_SPARE_B = 3'd7;
    localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_func;
    logic [31:0] i_push_value;
    logic [15:0] i_line_number;
    logic        o_strobe;
    logic [2:0]  o_status;
    logic [31:0] o_top_value;
    logic [8:0]  o_stack_count;
    logic [15:0] o_error_line;

    int    fail_count;
    int    pending;
    int    depth;
    int    sent;
    int    overflow_pushes;
    int    cycle_count;
    int    pick;
    bit    quiet;
    string halt_cause;

    stack_machine_alu i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .i_line_number (i_line_number),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_stack_count (o_stack_count),
        .o_error_line  (o_error_line)
    );

    stack_machine_alu_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .i_line_number (i_line_number),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_top_value   (o_top_value),
        .i_stack_count (o_stack_count),
        .i_error_line  (o_error_line),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] small_word();
        return 32'($urandom_range(0, 32)) - 32'd16;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return small_word();
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_line();
        return 16'($urandom);
    endfunction

    task automatic send(logic [2:0] func, logic [31:0] value, logic [15:0] line);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 7) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_func        <= func;
        i_push_value  <= value;
        i_line_number <= line;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sent++;
        case (func)
            FUNC_PUSH: begin
                if (depth < STACK_DEPTH_DEF) depth++;
                else overflow_pushes++;
            end
            FUNC_ADD, FUNC_SUB, FUNC_DIV: begin
                if (depth >= 2) depth--;
            end
            default: ;
        endcase
    endtask

    task automatic send_push(logic [31:0] value);
        send(FUNC_PUSH, value, rand_line());
    endtask

    task automatic send_op(logic [2:0] func);
        send(func, $urandom, rand_line());
    endtask

    // push a nonzero divisor, then divide the entry below it by it
    task automatic divide_by_fresh();
        logic [31:0] divisor;
        divisor = '0;
        while (divisor == '0)
            divisor = $urandom_range(0, 1) ? small_word() : rand_word();
        send_push(divisor);
        send_op(FUNC_DIV);
    endtask

    task automatic send_idle_op(int sel);
        case (sel % 3)
            0:       send_op(FUNC_SKIP);
            1:       send_op(FUNC_SPARE_A);
            default: send_op(FUNC_SPARE_B);
        endcase
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_SKIP;
        i_push_value    = '0;
        i_line_number   = '0;
        depth           = 0;
        sent            = 0;
        overflow_pushes = 0;
        quiet           = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(FUNC_SKIP, 32'hFFFF_FFFF, 16'h0000);
        send(FUNC_SPARE_A, 32'h0000_0000, 16'hFFFF);
        send(FUNC_SPARE_B, 32'h5A5A_A5A5, 16'h8001);
        send(FUNC_PUSH, WORD_MAX, 16'h0001);
        send(FUNC_PUSH, 32'd1, 16'h7FFF);
        send(FUNC_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send(FUNC_PUSH, 32'd1, 16'h0000);
        send(FUNC_SUB, 32'h0000_0000, 16'hFFFF);
        send(FUNC_PUSH, WORD_MIN, 16'h1234);
        send(FUNC_PUSH, 32'hFFFF_FFFF, 16'hFEDC);
        send(FUNC_DIV, 32'h0000_0000, 16'hFFFF);
        send(FUNC_SWAP, 32'hFFFF_FFFF, 16'h0000);
        send(FUNC_SUB, 32'h1357_9BDF, 16'hAAAA);
        send(FUNC_PUSH, -32'sd7, 16'h5555);
        send(FUNC_PUSH, 32'd2, 16'h0002);
        send(FUNC_DIV, 32'hFFFF_FFFF, 16'h0003);
        send(FUNC_PUSH, 32'd7, 16'h0004);
        send(FUNC_PUSH, -32'sd2, 16'h0005);
        send(FUNC_DIV, 32'h0000_0000, 16'h0006);
        send(FUNC_PUSH, 32'd5, 16'h0007);
        send(FUNC_PUSH, 32'd7, 16'h0008);
        send(FUNC_DIV, 32'hFFFF_FFFF, 16'h0009);
        send(FUNC_PUSH, 32'd0, 16'h000A);
        send(FUNC_SKIP, 32'h8000_0001, 16'h000B);
        send(FUNC_SPARE_A, 32'h7FFF_FFFE, 16'h000C);

        // random stack traffic at shallow depth
        repeat (WALK_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (depth < 2 || (pick < 35 && depth < 24)) send_push(rand_word());
            else if (pick < 50) send_op(FUNC_ADD);
            else if (pick < 62) send_op(FUNC_SUB);
            else if (pick < 72) send_op(FUNC_SWAP);
            else if (pick < 82) divide_by_fresh();
            else if (pick < 91) send_idle_op(pick);
            else send_push(rand_word());
        end

        // fill the stack back to back, then push into a full stack
        quiet = 1'b1;
        while (depth < STACK_DEPTH_DEF) begin
            if (depth >= 2 && $urandom_range(0, 9) == 0) send_op(FUNC_SWAP);
            else send_push(rand_word());
        end
        repeat (4) send_push(rand_word());
        quiet = 1'b0;

        // drain down to a single entry
        while (depth > 1) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) send_op(FUNC_ADD);
            else if (pick < 80) send_op(FUNC_SUB);
            else if (pick < 88) send_op(FUNC_SWAP);
            else if (pick < 94) divide_by_fresh();
            else send_idle_op(pick);
        end

        if ($urandom_range(0, 1)) begin
            halt_cause = "too few entries";
            send_op(3'($urandom_range(FUNC_SWAP, FUNC_DIV)));
        end else begin
            halt_cause = "a zero divisor";
            send_push('0);
            send_op(FUNC_DIV);
        end
        repeat (6) send(3'($urandom_range(0, 7)), rand_word(), rand_line());

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Ran %0d commands: corner values, random stack traffic, a full stack with %0d %s",
                 sent, overflow_pushes, "overflow pushes,");
        $display("then a halt on %s followed by commands in the halted state.", halt_cause);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
sv/sma_pkg.sv
sv/stack_machine_alu.sv
tb/stack_machine_alu_checker.sv
tb/stack_machine_alu_tb.sv
